/* src/clcd_seq_pkg.sv */
// ----------------------------------------------------------------------------
// Character LCD command sequencer package
// Shared constants, control word types and the sequencer program ROM.
// ----------------------------------------------------------------------------
package clcd_seq_pkg;

    localparam int LINE_CHARS = 16;
    localparam int CNT_W = $clog2(LINE_CHARS + 1);
    localparam int MAX_RES = 16;
    localparam int PAD_W = $clog2(MAX_RES);

    localparam int ACTION_W = 3;
    localparam int BYTE_W = 8;
    localparam int BEFORE_W = 20;
    localparam int AFTER_W = 16;
    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [BEFORE_W-1:0] POWERUP_MAX = BEFORE_W'(1000000);
    localparam logic [BYTE_W-1:0] CLEAR_CMD = 8'h01;
    localparam logic [BYTE_W-1:0] DDRAM_CMD = 8'h80;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [3:0] COL_MAX = 4'hF;

    localparam logic [ACTION_W-1:0] ACT_INIT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CURSOR = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CHAR = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CMD_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWERUP_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CTRL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MODE = 3'd5;

    localparam int PROG_LEN = 9;
    localparam int PC_W = $clog2(PROG_LEN);

    localparam logic [PC_W-1:0] PC_INIT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CLEAR = PC_W'(5);
    localparam logic [PC_W-1:0] PC_CURSOR = PC_W'(6);
    localparam logic [PC_W-1:0] PC_CHAR = PC_W'(7);
    localparam logic [PC_W-1:0] PC_FINISH = PC_W'(8);

    typedef enum logic [2:0] {
        BSEL_FSET,
        BSEL_DCTL,
        BSEL_CLEAR,
        BSEL_ENTRY,
        BSEL_CURSOR,
        BSEL_CHAR,
        BSEL_SPACE
    } byte_sel_t;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_DONE,
        OP_PAD
    } seq_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_CLEAR,
        CNT_INC
    } cnt_op_t;

    typedef struct packed {
        logic      rs;
        byte_sel_t byte_sel;
        logic      before_pw;
        logic      after_clear;
        seq_op_t   op;
        cnt_op_t   cnt_op;
    } ctrl_word_t;

    function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{rs: 1'b0, byte_sel: BSEL_CLEAR, before_pw: 1'b0, after_clear: 1'b1,
              op: OP_DONE, cnt_op: CNT_KEEP};
        unique case (pc)
            PC_W'(0): w = '{1'b0, BSEL_FSET, 1'b1, 1'b0, OP_NEXT, CNT_KEEP};
            PC_W'(1): w = '{1'b0, BSEL_FSET, 1'b0, 1'b0, OP_NEXT, CNT_KEEP};
            PC_W'(2): w = '{1'b0, BSEL_DCTL, 1'b0, 1'b0, OP_NEXT, CNT_KEEP};
            PC_W'(3): w = '{1'b0, BSEL_CLEAR, 1'b0, 1'b1, OP_NEXT, CNT_KEEP};
            PC_W'(4): w = '{1'b0, BSEL_ENTRY, 1'b0, 1'b0, OP_DONE, CNT_KEEP};
            PC_W'(5): w = '{1'b0, BSEL_CLEAR, 1'b0, 1'b1, OP_DONE, CNT_KEEP};
            PC_W'(6): w = '{1'b0, BSEL_CURSOR, 1'b0, 1'b0, OP_DONE, CNT_CLEAR};
            PC_W'(7): w = '{1'b1, BSEL_CHAR, 1'b0, 1'b0, OP_DONE, CNT_INC};
            PC_W'(8): w = '{1'b1, BSEL_SPACE, 1'b0, 1'b0, OP_PAD, CNT_INC};
            default: w = '{1'b0, BSEL_CLEAR, 1'b0, 1'b1, OP_DONE, CNT_KEEP};
        endcase
        return w;
    endfunction

endpackage

/* src/char_lcd_command_sequencer_core.sv */
// A request's first bus write is issued once the request is registered in the step counter
// and the output register is free. Throughput: the step counter issues one control word per
// cycle into the output register unless a word waits on m_axis_tready; no new request is
// taken until the last word is issued. Full-line finishes and unused actions emit none.
// Reset: rst_n is asynchronous and active low; it restores the register defaults,
// clears the line character count and leaves the block idle with no pending write.
// ----------------------------------------------------------------------------
// Character LCD command sequencer core
// Turns display requests into instruction and data bus writes with their wait
// times, driven by a small microcode program with a step counter.
// ----------------------------------------------------------------------------
module char_lcd_command_sequencer_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [clcd_seq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clcd_seq_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // line [7:0], column [15:8], char_code [23:16]
    input  logic [clcd_seq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action [2:0]
    input  logic [clcd_seq_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // bus_byte [7:0], wait_before_us [27:8], wait_after_us [43:28], zero [47:44]
    output logic [clcd_seq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // reg_select [0]
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);

    logic [15:0] cmd_delay_reg;
    logic [15:0] clear_delay_reg;
    logic [19:0] powerup_delay_reg;
    logic [7:0]  function_set_reg;
    logic [7:0]  display_ctrl_reg;
    logic [7:0]  entry_mode_reg;

    logic                               busy_reg, busy_next;
    logic [clcd_seq_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic [clcd_seq_pkg::PAD_W-1:0]     pad_cnt_reg, pad_cnt_next;
    logic [clcd_seq_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    logic       line_bit_reg;
    logic [3:0] col_reg;
    logic [7:0] char_reg;

    logic                                   m_valid_reg, m_valid_next;
    logic                                   m_rs_reg;
    logic                                   m_last_reg;
    logic [clcd_seq_pkg::BYTE_W-1:0]        m_byte_reg;
    logic [clcd_seq_pkg::BEFORE_W-1:0]      m_before_reg;
    logic [clcd_seq_pkg::AFTER_W-1:0]       m_after_reg;

    clcd_seq_pkg::ctrl_word_t           word;
    logic                               accept;
    logic                               action_ok;
    logic [clcd_seq_pkg::PC_W-1:0]      entry_pc;
    logic                               advance;
    logic                               line_full;
    logic                               skip;
    logic                               emit;
    logic                               is_last;
    logic [clcd_seq_pkg::BYTE_W-1:0]    byte_val;
    logic [clcd_seq_pkg::BEFORE_W-1:0]  before_val;
    logic [clcd_seq_pkg::AFTER_W-1:0]   after_val;
    logic [clcd_seq_pkg::BEFORE_W-1:0]  powerup_sat;
    logic [7:0]                         in_column;

    assign s_axis_tready = !busy_reg;
    assign accept = s_axis_tvalid && !busy_reg;
    assign in_column = s_axis_tdata[15:8];

    always_comb
    begin
        action_ok = 1'b1;
        entry_pc = clcd_seq_pkg::PC_INIT;
        unique case (s_axis_tuser)
            clcd_seq_pkg::ACT_INIT:   entry_pc = clcd_seq_pkg::PC_INIT;
            clcd_seq_pkg::ACT_CLEAR:  entry_pc = clcd_seq_pkg::PC_CLEAR;
            clcd_seq_pkg::ACT_CURSOR: entry_pc = clcd_seq_pkg::PC_CURSOR;
            clcd_seq_pkg::ACT_CHAR:   entry_pc = clcd_seq_pkg::PC_CHAR;
            clcd_seq_pkg::ACT_FINISH: entry_pc = clcd_seq_pkg::PC_FINISH;
            default:                  action_ok = 1'b0;
        endcase
    end

    assign powerup_sat = (powerup_delay_reg > clcd_seq_pkg::POWERUP_MAX) ?
                         clcd_seq_pkg::POWERUP_MAX : powerup_delay_reg;

    always_comb
    begin
        word = clcd_seq_pkg::prog_rom(pc_reg);
        line_full = (cnt_reg >= clcd_seq_pkg::CNT_W'(clcd_seq_pkg::LINE_CHARS));
        advance = busy_reg && (!m_valid_reg || m_axis_tready);
        skip = (word.op == clcd_seq_pkg::OP_PAD) && line_full;
        emit = advance && !skip;

        unique case (word.op)
            clcd_seq_pkg::OP_NEXT: is_last = 1'b0;
            clcd_seq_pkg::OP_DONE: is_last = 1'b1;
            clcd_seq_pkg::OP_PAD:
                is_last = (cnt_reg >= clcd_seq_pkg::CNT_W'(clcd_seq_pkg::LINE_CHARS - 1)) ||
                          (pad_cnt_reg == clcd_seq_pkg::PAD_W'(clcd_seq_pkg::MAX_RES - 1));
            default:               is_last = 1'b1;
        endcase

        unique case (word.byte_sel)
            clcd_seq_pkg::BSEL_FSET:   byte_val = function_set_reg;
            clcd_seq_pkg::BSEL_DCTL:   byte_val = display_ctrl_reg;
            clcd_seq_pkg::BSEL_CLEAR:  byte_val = clcd_seq_pkg::CLEAR_CMD;
            clcd_seq_pkg::BSEL_ENTRY:  byte_val = entry_mode_reg;
            clcd_seq_pkg::BSEL_CURSOR:
                byte_val = clcd_seq_pkg::DDRAM_CMD | {1'b0, line_bit_reg, 2'b00, col_reg};
            clcd_seq_pkg::BSEL_CHAR:   byte_val = char_reg;
            clcd_seq_pkg::BSEL_SPACE:  byte_val = clcd_seq_pkg::SPACE_CHAR;
            default:                   byte_val = clcd_seq_pkg::CLEAR_CMD;
        endcase

        before_val = word.before_pw ? powerup_sat : '0;
        after_val = word.after_clear ? clear_delay_reg : cmd_delay_reg;

        busy_next = busy_reg;
        pc_next = pc_reg;
        pad_cnt_next = pad_cnt_reg;
        cnt_next = cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;

        if (accept)
        begin
            busy_next = action_ok;
            pc_next = entry_pc;
            pad_cnt_next = '0;
        end
        else if (advance)
        begin
            if (skip || is_last)
            begin
                busy_next = 1'b0;
            end
            else if (word.op == clcd_seq_pkg::OP_NEXT)
            begin
                pc_next = pc_reg + 1'b1;
            end
            else
            begin
                pad_cnt_next = pad_cnt_reg + 1'b1;
            end
        end

        if (emit)
        begin
            m_valid_next = 1'b1;
            unique case (word.cnt_op)
                clcd_seq_pkg::CNT_KEEP:  cnt_next = cnt_reg;
                clcd_seq_pkg::CNT_CLEAR: cnt_next = '0;
                clcd_seq_pkg::CNT_INC:   cnt_next = line_full ? cnt_reg : cnt_reg + 1'b1;
                default:                 cnt_next = cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_delay_reg <= 16'd40;
            clear_delay_reg <= 16'd2000;
            powerup_delay_reg <= 20'd100000;
            function_set_reg <= 8'h3C;
            display_ctrl_reg <= 8'h0C;
            entry_mode_reg <= 8'h06;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                clcd_seq_pkg::CFG_CMD_DELAY:     cmd_delay_reg <= cfg_wdata[15:0];
                clcd_seq_pkg::CFG_CLEAR_DELAY:   clear_delay_reg <= cfg_wdata[15:0];
                clcd_seq_pkg::CFG_POWERUP_DELAY: powerup_delay_reg <= cfg_wdata;
                clcd_seq_pkg::CFG_FUNCTION_SET:  function_set_reg <= cfg_wdata[7:0];
                clcd_seq_pkg::CFG_DISPLAY_CTRL:  display_ctrl_reg <= cfg_wdata[7:0];
                clcd_seq_pkg::CFG_ENTRY_MODE:    entry_mode_reg <= cfg_wdata[7:0];
                default:                         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg <= '0;
            pad_cnt_reg <= '0;
            cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg <= pc_next;
            pad_cnt_reg <= pad_cnt_next;
            cnt_reg <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_bit_reg <= s_axis_tdata[0];
            col_reg <= (in_column > 8'(clcd_seq_pkg::COL_MAX)) ?
                       clcd_seq_pkg::COL_MAX : in_column[3:0];
            char_reg <= s_axis_tdata[23:16];
        end
        if (emit)
        begin
            m_rs_reg <= word.rs;
            m_byte_reg <= byte_val;
            m_before_reg <= before_val;
            m_after_reg <= after_val;
            m_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser = m_rs_reg;
    assign m_axis_tlast = m_last_reg;
    assign m_axis_tdata = {4'b0000, m_after_reg, m_before_reg, m_byte_reg};

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= clcd_seq_pkg::CNT_W'(clcd_seq_pkg::LINE_CHARS))
        else $error("line character count exceeds the line length");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg < clcd_seq_pkg::PC_W'(clcd_seq_pkg::PROG_LEN)))
        else $error("step counter outside the program");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_last) |=> !busy_reg)
        else $error("sequencer still busy after its final word");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action_ok) |=> (busy_reg && pc_reg == $past(entry_pc)))
        else $error("request did not start at its program entry");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!m_valid_reg || m_axis_tready))
        else $error("word issued over a pending word");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD command sequencer testbench
// Drives display requests into the sequencer stream port and checks every
// bus write it emits against a cycle-free model of the request decoding, the
// line character count and the register set. A short table of directed
// requests runs at the reset settings, then random line-building traffic runs
// under several register settings, with random gaps and output backpressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned LIMIT_CYCLES = 1000000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int N_DIR = 22;

    localparam logic [clcd_seq_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [clcd_seq_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [clcd_seq_pkg::ACTION_W-1:0] ACT_SPARE_C = 3'd7;

    typedef struct packed {
        logic                              rs;
        logic [clcd_seq_pkg::BYTE_W-1:0]   bus_byte;
        logic [clcd_seq_pkg::BEFORE_W-1:0] before_us;
        logic [clcd_seq_pkg::AFTER_W-1:0]  after_us;
        logic                              last;
    } bus_write_t;

    typedef struct packed {
        logic [clcd_seq_pkg::ACTION_W-1:0] act;
        logic [7:0]                        ln;
        logic [7:0]                        col;
        logic [7:0]                        ch;
        logic                              typed;
        logic [4:0]                        n;
        logic                              rs;
        logic [clcd_seq_pkg::BYTE_W-1:0]   bb;
        logic [clcd_seq_pkg::AFTER_W-1:0]  after_us;
    } request_row_t;

    localparam request_row_t DIR_ROWS [N_DIR] = '{
        '{clcd_seq_pkg::ACT_INIT,   8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_CLEAR,  8'h00, 8'h00, 8'h00, 1'b1, 5'd1, 1'b0, 8'h01, 16'd2000},
        '{clcd_seq_pkg::ACT_CURSOR, 8'h00, 8'h00, 8'h00, 1'b1, 5'd1, 1'b0, 8'h80, 16'd40},
        '{clcd_seq_pkg::ACT_CURSOR, 8'hFF, 8'hFF, 8'hFF, 1'b1, 5'd1, 1'b0, 8'hCF, 16'd40},
        '{clcd_seq_pkg::ACT_CURSOR, 8'h01, 8'h0F, 8'h00, 1'b1, 5'd1, 1'b0, 8'hCF, 16'd40},
        '{clcd_seq_pkg::ACT_CURSOR, 8'hFE, 8'h10, 8'h00, 1'b1, 5'd1, 1'b0, 8'h8F, 16'd40},
        '{clcd_seq_pkg::ACT_CHAR,   8'h00, 8'h00, 8'h00, 1'b1, 5'd1, 1'b1, 8'h00, 16'd40},
        '{clcd_seq_pkg::ACT_CHAR,   8'hFF, 8'hFF, 8'hFF, 1'b1, 5'd1, 1'b1, 8'hFF, 16'd40},
        '{clcd_seq_pkg::ACT_FINISH, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_FINISH, 8'h00, 8'h00, 8'h00, 1'b1, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_CHAR,   8'h00, 8'h00, 8'h41, 1'b1, 5'd1, 1'b1, 8'h41, 16'd40},
        '{clcd_seq_pkg::ACT_FINISH, 8'hFF, 8'hFF, 8'hFF, 1'b1, 5'd0, 1'b0, 8'h00, 16'd0},
        '{ACT_SPARE_A,              8'hFF, 8'hFF, 8'hFF, 1'b1, 5'd0, 1'b0, 8'h00, 16'd0},
        '{ACT_SPARE_B,              8'h00, 8'h00, 8'h00, 1'b1, 5'd0, 1'b0, 8'h00, 16'd0},
        '{ACT_SPARE_C,              8'h5A, 8'hA5, 8'h3C, 1'b1, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_CURSOR, 8'h00, 8'h05, 8'h00, 1'b1, 5'd1, 1'b0, 8'h85, 16'd40},
        '{clcd_seq_pkg::ACT_FINISH, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_CURSOR, 8'h01, 8'h00, 8'h00, 1'b1, 5'd1, 1'b0, 8'hC0, 16'd40},
        '{clcd_seq_pkg::ACT_CHAR,   8'h00, 8'h00, 8'h55, 1'b0, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_CLEAR,  8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_INIT,   8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0, 8'h00, 16'd0},
        '{clcd_seq_pkg::ACT_FINISH, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0, 1'b0, 8'h00, 16'd0}
    };

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [clcd_seq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [clcd_seq_pkg::CFG_W-1:0]      cfg_wdata;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [clcd_seq_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [clcd_seq_pkg::ACTION_W-1:0]   s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [clcd_seq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                                m_axis_tuser;
    logic                                m_axis_tlast;

    logic [clcd_seq_pkg::AFTER_W-1:0]  cmd_us;
    logic [clcd_seq_pkg::AFTER_W-1:0]  clear_us;
    logic [clcd_seq_pkg::BEFORE_W-1:0] powerup_us;
    logic [clcd_seq_pkg::BYTE_W-1:0]   fset_byte;
    logic [clcd_seq_pkg::BYTE_W-1:0]   dctl_byte;
    logic [clcd_seq_pkg::BYTE_W-1:0]   entry_byte;
    logic [clcd_seq_pkg::CNT_W-1:0]    chars_on_line;

    bus_write_t  expected_writes [$];
    int unsigned errors;
    int unsigned cycles;
    bit          tx_steady;
    bit          rx_steady;
    int unsigned rx_stall_left;

    char_lcd_command_sequencer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic void queue_write(input logic rs,
                                        input logic [clcd_seq_pkg::BYTE_W-1:0] bb,
                                        input logic [clcd_seq_pkg::BEFORE_W-1:0] before_us,
                                        input logic [clcd_seq_pkg::AFTER_W-1:0] after_us,
                                        input logic last);
        expected_writes.push_back('{rs, bb, before_us, after_us, last});
    endfunction

    function automatic void predict_writes(input logic [clcd_seq_pkg::ACTION_W-1:0] act,
                                           input logic [7:0] ln, input logic [7:0] col,
                                           input logic [7:0] ch);
        logic [clcd_seq_pkg::BEFORE_W-1:0] pw;
        logic [3:0]                        col_cap;
        int unsigned                       spaces;
        pw = (powerup_us > clcd_seq_pkg::POWERUP_MAX) ?
             clcd_seq_pkg::POWERUP_MAX : powerup_us;
        col_cap = (col > 8'(clcd_seq_pkg::COL_MAX)) ? clcd_seq_pkg::COL_MAX : col[3:0];
        case (act)
            clcd_seq_pkg::ACT_INIT:
            begin
                queue_write(1'b0, fset_byte, pw, cmd_us, 1'b0);
                queue_write(1'b0, fset_byte, '0, cmd_us, 1'b0);
                queue_write(1'b0, dctl_byte, '0, cmd_us, 1'b0);
                queue_write(1'b0, clcd_seq_pkg::CLEAR_CMD, '0, clear_us, 1'b0);
                queue_write(1'b0, entry_byte, '0, cmd_us, 1'b1);
            end
            clcd_seq_pkg::ACT_CLEAR:
                queue_write(1'b0, clcd_seq_pkg::CLEAR_CMD, '0, clear_us, 1'b1);
            clcd_seq_pkg::ACT_CURSOR:
            begin
                queue_write(1'b0, clcd_seq_pkg::DDRAM_CMD | {1'b0, ln[0], 2'b00, col_cap},
                            '0, cmd_us, 1'b1);
                chars_on_line = '0;
            end
            clcd_seq_pkg::ACT_CHAR:
            begin
                queue_write(1'b1, ch, '0, cmd_us, 1'b1);
                if (chars_on_line < clcd_seq_pkg::CNT_W'(clcd_seq_pkg::LINE_CHARS))
                    chars_on_line = chars_on_line + 1'b1;
            end
            clcd_seq_pkg::ACT_FINISH:
            begin
                spaces = (chars_on_line < clcd_seq_pkg::CNT_W'(clcd_seq_pkg::LINE_CHARS)) ?
                         clcd_seq_pkg::LINE_CHARS - chars_on_line : 0;
                if (spaces > clcd_seq_pkg::MAX_RES)
                    spaces = clcd_seq_pkg::MAX_RES;
                for (int k = 0; k < spaces; k++)
                    queue_write(1'b1, clcd_seq_pkg::SPACE_CHAR, '0, cmd_us, k == spaces - 1);
                chars_on_line = chars_on_line + clcd_seq_pkg::CNT_W'(spaces);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void apply_reg(input logic [clcd_seq_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [clcd_seq_pkg::CFG_W-1:0] data);
        case (idx)
            clcd_seq_pkg::CFG_CMD_DELAY:     cmd_us = data[clcd_seq_pkg::AFTER_W-1:0];
            clcd_seq_pkg::CFG_CLEAR_DELAY:   clear_us = data[clcd_seq_pkg::AFTER_W-1:0];
            clcd_seq_pkg::CFG_POWERUP_DELAY: powerup_us = data[clcd_seq_pkg::BEFORE_W-1:0];
            clcd_seq_pkg::CFG_FUNCTION_SET:  fset_byte = data[clcd_seq_pkg::BYTE_W-1:0];
            clcd_seq_pkg::CFG_DISPLAY_CTRL:  dctl_byte = data[clcd_seq_pkg::BYTE_W-1:0];
            clcd_seq_pkg::CFG_ENTRY_MODE:    entry_byte = data[clcd_seq_pkg::BYTE_W-1:0];
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [clcd_seq_pkg::ACTION_W-1:0] pick_action();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return clcd_seq_pkg::ACT_INIT;
        else if (r < 15)
            return clcd_seq_pkg::ACT_CLEAR;
        else if (r < 30)
            return clcd_seq_pkg::ACT_CURSOR;
        else if (r < 60)
            return clcd_seq_pkg::ACT_CHAR;
        else if (r < 82)
            return clcd_seq_pkg::ACT_FINISH;
        return clcd_seq_pkg::ACTION_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
    endfunction

    function automatic request_row_t random_row(
        input logic [clcd_seq_pkg::ACTION_W-1:0] act);
        request_row_t row;
        row = '0;
        row.act = act;
        row.ln = 8'($urandom_range(0, 255));
        row.col = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        row.ch = 8'($urandom_range(0, 255));
        return row;
    endfunction

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic pace_sender();
        int unsigned r;
        int unsigned gap;
        r = $urandom_range(0, 99);
        if (!tx_steady && r < 40)
        begin
            gap = (r < 34) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_request(input request_row_t row);
        int unsigned base;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= row.act;
        s_axis_tdata <= {row.ch, row.col, row.ln};
        do
            @(posedge clk);
        while (!s_axis_tready);
        base = expected_writes.size();
        predict_writes(row.act, row.ln, row.col, row.ch);
        if (row.typed)
        begin
            while (expected_writes.size() > base)
                void'(expected_writes.pop_back());
            if (row.n != 0)
                queue_write(row.rs, row.bb, '0, row.after_us, 1'b1);
        end
        pace_sender();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [clcd_seq_pkg::CFG_W-1:0] cmd,
                                 input logic [clcd_seq_pkg::CFG_W-1:0] clr,
                                 input logic [clcd_seq_pkg::CFG_W-1:0] pw,
                                 input logic [clcd_seq_pkg::CFG_W-1:0] fset,
                                 input logic [clcd_seq_pkg::CFG_W-1:0] dctl,
                                 input logic [clcd_seq_pkg::CFG_W-1:0] entry,
                                 input bit spares);
        logic [clcd_seq_pkg::CFG_W-1:0] vals [8];
        vals = '{cmd, clr, pw, fset, dctl, entry,
                 clcd_seq_pkg::CFG_W'($urandom), clcd_seq_pkg::CFG_W'($urandom)};
        for (int i = 0; i < 8; i++)
        begin
            if (i <= int'(clcd_seq_pkg::CFG_ENTRY_MODE) || spares)
            begin
                cfg_we <= 1'b1;
                cfg_index <= clcd_seq_pkg::CFG_IDX_W'(i);
                cfg_wdata <= vals[i];
                @(posedge clk);
                apply_reg(clcd_seq_pkg::CFG_IDX_W'(i), vals[i]);
            end
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned  sent;
        int unsigned  k;
        bit           held;
        request_row_t row;
        sent = 0;
        held = 0;
        while (sent < target)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if (!held && sent >= target / 2)
            begin
                hold_until_drained();
                held = 1;
            end
            if ($urandom_range(0, 99) < 55)
            begin
                send_request(random_row(clcd_seq_pkg::ACT_CURSOR));
                sent++;
                k = $urandom_range(0, 18);
                repeat (k)
                begin
                    send_request(random_row(clcd_seq_pkg::ACT_CHAR));
                    sent++;
                end
                if ($urandom_range(0, 99) < 85)
                begin
                    send_request(random_row(clcd_seq_pkg::ACT_FINISH));
                    sent++;
                end
            end
            else
            begin
                row = random_row(pick_action());
                send_request(row);
                if (row.act <= clcd_seq_pkg::ACT_FINISH)
                    sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin : bus_write_check
        bus_write_t want;
        int unsigned r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_writes.size() == 0)
            begin
                $error("unexpected bus write: bus_byte %0h",
                       m_axis_tdata[clcd_seq_pkg::BYTE_W-1:0]);
                errors++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (m_axis_tuser !== want.rs)
                begin
                    $error("reg_select: expected %0h, actual %0h", want.rs, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[clcd_seq_pkg::BYTE_W-1:0] !== want.bus_byte)
                begin
                    $error("bus_byte: expected %0h, actual %0h", want.bus_byte,
                           m_axis_tdata[clcd_seq_pkg::BYTE_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[clcd_seq_pkg::BYTE_W +: clcd_seq_pkg::BEFORE_W] !==
                    want.before_us)
                begin
                    $error("wait_before_us: expected %0d, actual %0d", want.before_us,
                           m_axis_tdata[clcd_seq_pkg::BYTE_W +: clcd_seq_pkg::BEFORE_W]);
                    errors++;
                end
                if (m_axis_tdata[clcd_seq_pkg::BYTE_W+clcd_seq_pkg::BEFORE_W +:
                                 clcd_seq_pkg::AFTER_W] !== want.after_us)
                begin
                    $error("wait_after_us: expected %0d, actual %0d", want.after_us,
                           m_axis_tdata[clcd_seq_pkg::BYTE_W+clcd_seq_pkg::BEFORE_W +:
                                        clcd_seq_pkg::AFTER_W]);
                    errors++;
                end
                if (m_axis_tdata[clcd_seq_pkg::OUT_DATA_W-1:
                                 clcd_seq_pkg::BYTE_W+clcd_seq_pkg::BEFORE_W+
                                 clcd_seq_pkg::AFTER_W] !== '0)
                begin
                    $error("pad: expected 0, actual %0h",
                           m_axis_tdata[clcd_seq_pkg::OUT_DATA_W-1:
                                        clcd_seq_pkg::BYTE_W+clcd_seq_pkg::BEFORE_W+
                                        clcd_seq_pkg::AFTER_W]);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0h, actual %0h", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        if ($urandom_range(0, 127) == 0)
            rx_steady = !rx_steady;
        if (rx_stall_left != 0)
        begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_steady)
            m_axis_tready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                m_axis_tready <= 1'b1;
            else
            begin
                rx_stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                m_axis_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        cycles = 0;
        tx_steady = 0;
        rx_steady = 0;
        rx_stall_left = 0;
        cmd_us = 16'd40;
        clear_us = 16'd2000;
        powerup_us = 20'd100000;
        fset_byte = 8'h3C;
        dctl_byte = 8'h0C;
        entry_byte = 8'h06;
        chars_on_line = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_request(DIR_ROWS[i]);
        drain();

        load_settings('0, '0, '0, '0, '0, '0, 1'b0);
        run_random(PHASE_ITEMS);
        drain();

        load_settings('1, '1, '1, '1, '1, '1, 1'b0);
        run_random(PHASE_ITEMS);
        drain();

        load_settings(clcd_seq_pkg::CFG_W'($urandom_range(0, 65535)),
                      clcd_seq_pkg::CFG_W'($urandom_range(0, 65535)),
                      clcd_seq_pkg::CFG_W'(clcd_seq_pkg::POWERUP_MAX) + 1'b1,
                      clcd_seq_pkg::CFG_W'($urandom_range(0, 255)),
                      clcd_seq_pkg::CFG_W'($urandom_range(0, 255)),
                      clcd_seq_pkg::CFG_W'($urandom_range(0, 255)), 1'b0);
        run_random(PHASE_ITEMS);
        drain();

        load_settings(clcd_seq_pkg::CFG_W'($urandom), clcd_seq_pkg::CFG_W'($urandom),
                      clcd_seq_pkg::CFG_W'($urandom_range(0, 1000000)),
                      clcd_seq_pkg::CFG_W'($urandom), clcd_seq_pkg::CFG_W'($urandom),
                      clcd_seq_pkg::CFG_W'($urandom), 1'b1);
        run_random(PHASE_ITEMS);
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
